>>> rtl/dss_pkg.sv
// ---------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the detection score smoother: field widths,
// register reset values, request and register index codes, and the result
// and configuration structures passed between the modules.
// ---------------------------------------------------------------------------
package dss_pkg;

   localparam int WINDOW_LEN_DEFAULT = 8;

   localparam int SCORE_W   = 8;
   localparam int SUM_OUT_W = 11;
   localparam int CFG_W     = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] CUTOFF_RESET = 8'd128;
   localparam logic [CFG_W-1:0] REARM_RESET  = 8'd50;
   localparam logic [CFG_W-1:0] SETTLE_RESET = 8'd20;

   typedef enum logic {
      REQ_SCORE = 1'b0,
      REQ_REARM = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CUTOFF = 2'd0,
      CSR_REARM  = 2'd1,
      CSR_SETTLE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] cutoff_raw;
      logic [CFG_W-1:0] rearm_windows;
      logic [CFG_W-1:0] settle_windows;
   } cfg_type;

   typedef struct packed {
      logic                 detected;
      logic [SUM_OUT_W-1:0] window_sum;
      logic                 window_full;
      logic                 holding_off;
   } result_type;

endpackage

>>> rtl/dss_csr.sv
// ---------------------------------------------------------------------------
// dss_csr
// Configuration registers: threshold, rearm holdoff and settle holdoff.
// Writes to an index beyond the register list are dropped.
// ---------------------------------------------------------------------------
module dss_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dss_pkg::CFG_W-1:0]       csr_data,
   output dss_pkg::cfg_type                cfg
);

   dss_pkg::cfg_type cfg_ff;
   dss_pkg::cfg_type cfg_in;
   logic             write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_index)
            dss_pkg::CSR_CUTOFF: cfg_in.cutoff_raw     = csr_data;
            dss_pkg::CSR_REARM:  cfg_in.rearm_windows  = csr_data;
            dss_pkg::CSR_SETTLE: cfg_in.settle_windows = csr_data;
            default:             cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cutoff_raw     <= dss_pkg::CUTOFF_RESET;
         cfg_ff.rearm_windows  <= dss_pkg::REARM_RESET;
         cfg_ff.settle_windows <= dss_pkg::SETTLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/dss_core.sv
// ---------------------------------------------------------------------------
// dss_core
// Score ring, running sum, fill count and holdoff counter. The ring is a
// memory with a registered read port that always holds the entry at the
// current write slot, so each score costs one subtract, one add and one
// compare.
// ---------------------------------------------------------------------------
module dss_core #(
   parameter int WINDOW_LEN = dss_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          req_type,
   input  logic [dss_pkg::SCORE_W-1:0]   req_score,
   input  dss_pkg::cfg_type              cfg,
   output dss_pkg::result_type           result
);

   localparam int SUM_W  = $clog2(WINDOW_LEN * 255 + 1);
   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

   logic [dss_pkg::SCORE_W-1:0] ring_ff [WINDOW_LEN];
   logic [dss_pkg::SCORE_W-1:0] oldest_ff;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic [SUM_W-1:0]            sum_ff, sum_in;
   logic [dss_pkg::CFG_W-1:0]   hold_ff, hold_in;

   logic                        is_rearm;
   logic                        ring_write;
   logic                        was_full;
   logic                        now_full;
   logic [dss_pkg::SCORE_W-1:0] old_score;
   logic [SUM_W-1:0]            threshold;
   logic [SUM_W+dss_pkg::SUM_OUT_W-1:0] sum_wide;

   assign is_rearm   = (req_type == dss_pkg::REQ_REARM);
   assign ring_write = accept && !is_rearm;
   assign was_full   = (fill_ff == FILL_W'(WINDOW_LEN));
   // Entries beyond the fill count are stale after a rearm, so they count as zero.
   assign old_score  = was_full ? oldest_ff : '0;
   assign threshold  = SUM_W'(cfg.cutoff_raw) * SUM_W'(WINDOW_LEN);

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      hold_in = hold_ff;
      result  = '0;
      if (accept) begin
         if (is_rearm) begin
            slot_in = '0;
            fill_in = '0;
            sum_in  = '0;
            hold_in = cfg.settle_windows;
         end else begin
            sum_in  = sum_ff - SUM_W'(old_score) + SUM_W'(req_score);
            slot_in = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;
            fill_in = was_full ? fill_ff : fill_ff + 1'b1;
         end
      end
      now_full = (fill_in == FILL_W'(WINDOW_LEN));
      if (ring_write) begin
         if (hold_ff != '0) begin
            hold_in            = hold_ff - 1'b1;
            result.holding_off = 1'b1;
         end else if (now_full && (sum_in > threshold)) begin
            result.detected = 1'b1;
            hold_in         = cfg.rearm_windows;
         end
         result.window_full = now_full;
      end
      sum_wide          = {{dss_pkg::SUM_OUT_W{1'b0}}, sum_in};
      result.window_sum = is_rearm ? '0 : sum_wide[dss_pkg::SUM_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
         hold_ff <= dss_pkg::SETTLE_RESET;
      end else begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
         hold_ff <= hold_in;
      end
   end

   // The read port follows the next write slot; with a one-entry ring that
   // slot is the one being written, so the new score is passed straight on.
   always_ff @(posedge clock) begin
      if (ring_write) begin
         ring_ff[slot_ff] <= req_score;
      end
      if (ring_write && (slot_in == slot_ff)) begin
         oldest_ff <= req_score;
      end else begin
         oldest_ff <= ring_ff[slot_in];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      accept && is_rearm |=> (fill_ff == '0) && (sum_ff == '0) && (slot_ff == '0))
      else $error("rearm did not clear the window");

   assert property (@(posedge clock) disable iff (reset)
      accept && result.detected |=> hold_ff == $past(cfg.rearm_windows))
      else $error("detection did not load the rearm holdoff");

   assert property (@(posedge clock) disable iff (reset)
      ring_write && (hold_ff != '0) |=> hold_ff == $past(hold_ff) - 1'b1)
      else $error("holdoff did not count down");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff != FILL_W'(WINDOW_LEN)) |-> (slot_ff == SLOT_W'(fill_ff)))
      else $error("write slot out of step with fill count");

endmodule

>>> rtl/dss_out.sv
// ---------------------------------------------------------------------------
// dss_out
// Result register with a skid stage behind it. The input side is stalled
// only while the skid stage holds a word, so it never waits on the result
// side combinationally.
// ---------------------------------------------------------------------------
module dss_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_accept,
   input  dss_pkg::result_type  in_result,
   output logic                 in_stall,
   output logic                 out_valid,
   input  logic                 out_stall,
   output dss_pkg::result_type  out_result
);

   logic                main_valid_ff, main_valid_in;
   dss_pkg::result_type main_ff, main_in;
   logic                skid_valid_ff, skid_valid_in;
   dss_pkg::result_type skid_ff, skid_in;
   logic                drain;

   assign drain = !main_valid_ff || !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (drain) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_accept;
            main_in       = in_result;
         end
      end else if (in_accept) begin
         skid_valid_in = 1'b1;
         skid_in       = in_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign in_stall   = skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_result = main_ff;

endmodule

>>> rtl/detection_score_smoother_top.sv
// ---------------------------------------------------------------------------
// detection_score_smoother_top
// Moving-average threshold detector with holdoff over a ring of scores.
// ---------------------------------------------------------------------------
// The block takes one score or rearm word per clock while req_stall is low
// and returns one result word for each, in order, via the result register
// and its skid stage. That rate is set by the combinational update of the
// running sum against the ring memory, whose read port is prefetched at the
// next write slot. A detection fires when the sum of the last WINDOW_LEN
// scores exceeds cutoff_raw times WINDOW_LEN, and only once the ring is
// full and no holdoff is counting down. Configuration writes are taken in
// every cycle and apply to later words; write them only while idle.
module detection_score_smoother_top #(
   parameter int WINDOW_LEN = dss_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [dss_pkg::SCORE_W-1:0]       req_score,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_detected,
   output logic [dss_pkg::SUM_OUT_W-1:0]     rsp_window_sum,
   output logic                              rsp_window_full,
   output logic                              rsp_holding_off,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dss_pkg::CFG_W-1:0]         csr_data
);

   dss_pkg::cfg_type    cfg;
   dss_pkg::result_type core_result;
   dss_pkg::result_type out_result;
   logic                accept;

   assign accept = req_valid && !req_stall;

   dss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dss_core #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_type  (req_type),
      .req_score (req_score),
      .cfg       (cfg),
      .result    (core_result)
   );

   dss_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (accept),
      .in_result  (core_result),
      .in_stall   (req_stall),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (out_result)
   );

   assign rsp_detected    = out_result.detected;
   assign rsp_window_sum  = out_result.window_sum;
   assign rsp_window_full = out_result.window_full;
   assign rsp_holding_off = out_result.holding_off;

endmodule
